// ===== design/npps_pkg.sv =====
package npps_pkg;

    // Defaults for the top-level parameters
    localparam int SLOTS_DEF      = 16;
    localparam int TIME_BITS_DEF  = 16;
    localparam int BURST_BITS_DEF = 12;

    // Fixed field widths of the beats
    localparam int PRI_W         = 4;
    localparam int BURST_FIELD_W = 12;
    localparam int SLOT_FIELD_W  = 4;
    localparam int TIME_FIELD_W  = 16;

    // Operation codes
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef struct packed {
        logic                     operation;
        logic [PRI_W-1:0]         task_priority;
        logic [BURST_FIELD_W-1:0] task_burst;
    } npps_in_t;

    typedef struct packed {
        logic                    accepted;
        logic [SLOT_FIELD_W-1:0] assigned_slot;
        logic                    running_valid;
        logic [SLOT_FIELD_W-1:0] running_slot;
        logic                    finished;
        logic [SLOT_FIELD_W-1:0] finished_slot;
        logic [TIME_FIELD_W-1:0] turnaround;
        logic [TIME_FIELD_W-1:0] waiting;
        logic [TIME_FIELD_W-1:0] time_now;
    } npps_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_PICK,
        ST_RUN,
        ST_CALC,
        ST_WAIT,
        ST_DONE
    } npps_state_t;

    typedef struct packed {
        logic start;
        logic add_step;
        logic pick_step;
        logic run_step;
        logic calc_step;
        logic wait_step;
        logic load_out;
    } npps_cmd_t;

    typedef struct packed {
        logic in_op;
        logic busy;
        logic add_done;
        logic pick_done;
        logic run_go;
        logic res_free;
    } npps_status_t;

endpackage

// ===== design/npps_dp.sv =====
module npps_dp
    import npps_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int BURST_BITS = BURST_BITS_DEF
)(
    input  logic         clk,
    input  logic         rst_n,
    input  npps_cmd_t    cmd,
    output npps_status_t status,
    input  npps_in_t     task_data,
    output npps_out_t    result_data,
    output logic         result_valid,
    input  logic         result_ready
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] SCAN_END = CNT_W'(SLOTS);

    // Task table
    logic [PRI_W-1:0]      mem_pri   [SLOTS];
    logic [TIME_BITS-1:0]  mem_arr   [SLOTS];
    logic [BURST_BITS-1:0] mem_burst [SLOTS];
    logic [BURST_BITS-1:0] mem_rem   [SLOTS];

    // Control state
    logic [SLOTS-1:0]     valid_reg, valid_next;
    logic                 busy_reg, busy_next;
    logic [IDX_W-1:0]     cur_reg, cur_next;
    logic [TIME_BITS-1:0] tick_reg, tick_next;
    logic [CNT_W-1:0]     scan_reg, scan_next;
    logic                 pend_reg, pend_next;
    logic                 found_reg, found_next;
    logic                 out_valid_reg, out_valid_next;

    // Payload
    logic [PRI_W-1:0]      pri_reg;
    logic [BURST_BITS-1:0] burst_reg;
    logic [IDX_W-1:0]      best_slot_reg;
    logic [PRI_W-1:0]      best_pri_reg;
    logic [TIME_BITS-1:0]  best_age_reg;
    logic [IDX_W-1:0]      rd_slot_reg;
    logic [PRI_W-1:0]      rd_pri_reg;
    logic [TIME_BITS-1:0]  rd_arr_reg;
    logic [BURST_BITS-1:0] rd_burst_reg;
    logic [BURST_BITS-1:0] rd_rem_reg;
    logic                  wk_acc_reg;
    logic [IDX_W-1:0]      wk_slot_reg;
    logic                  wk_run_reg;
    logic                  wk_fin_reg;
    logic [TIME_BITS-1:0]  ta_reg;
    logic [TIME_BITS-1:0]  wait_reg;
    npps_out_t             out_reg, out_next;

    logic [IDX_W-1:0]      scan_idx;
    logic                  scan_live;
    logic                  scan_free;
    logic                  burst_zero;
    logic                  add_hit;
    logic [TIME_BITS-1:0]  age;
    logic                  better;
    logic                  take;
    logic                  run_go;
    logic [IDX_W-1:0]      run_slot;
    logic [BURST_BITS-1:0] rem_dec;
    logic                  fin;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  wr_add;
    logic                  wr_rem;
    logic [IDX_W-1:0]      wr_addr;
    logic [BURST_BITS-1:0] wr_rem_data;

    assign scan_idx   = scan_reg[IDX_W-1:0];
    assign scan_live  = scan_reg < SCAN_END;
    assign scan_free  = scan_live && !valid_reg[scan_idx];
    assign burst_zero = burst_reg == '0;
    assign add_hit    = !burst_zero && scan_free;

    // Priority, then age, then slot order (earlier slot kept on a tie)
    assign age    = tick_reg - rd_arr_reg;
    assign better = !found_reg || (rd_pri_reg < best_pri_reg) ||
                    ((rd_pri_reg == best_pri_reg) && (age > best_age_reg));
    assign take   = cmd.pick_step && pend_reg && valid_reg[rd_slot_reg] && better;

    assign run_go   = busy_reg || found_reg;
    assign run_slot = busy_reg ? cur_reg : best_slot_reg;
    assign rem_dec  = (rd_rem_reg != '0) ? (rd_rem_reg - BURST_BITS'(1)) : rd_rem_reg;
    assign fin      = rem_dec == '0;

    assign rd_en       = (cmd.pick_step && scan_live) || cmd.run_step;
    assign rd_addr     = cmd.run_step ? run_slot : scan_idx;
    assign wr_add      = cmd.add_step && add_hit;
    assign wr_rem      = wr_add || cmd.calc_step;
    assign wr_addr     = cmd.calc_step ? cur_reg : scan_idx;
    assign wr_rem_data = cmd.calc_step ? rem_dec : burst_reg;

    assign status.in_op     = task_data.operation;
    assign status.busy      = busy_reg;
    assign status.add_done  = burst_zero || !scan_live || scan_free;
    assign status.pick_done = !scan_live && !pend_reg;
    assign status.run_go    = run_go;
    assign status.res_free  = !out_valid_reg || result_ready;

    assign result_data  = out_reg;
    assign result_valid = out_valid_reg;

    always_comb
    begin
        valid_next     = valid_reg;
        busy_next      = busy_reg;
        cur_next       = cur_reg;
        tick_next      = tick_reg;
        scan_next      = scan_reg;
        pend_next      = pend_reg;
        found_next     = found_reg;
        out_valid_next = out_valid_reg;

        if (cmd.start)
        begin
            scan_next  = '0;
            pend_next  = 1'b0;
            found_next = 1'b0;
        end
        if (cmd.add_step)
        begin
            if (wr_add)
                valid_next[scan_idx] = 1'b1;
            else if (!status.add_done)
                scan_next = scan_reg + CNT_W'(1);
        end
        if (cmd.pick_step)
        begin
            pend_next = scan_live;
            if (scan_live)
                scan_next = scan_reg + CNT_W'(1);
            if (take)
                found_next = 1'b1;
        end
        if (cmd.run_step)
        begin
            busy_next = run_go;
            if (!busy_reg && found_reg)
                cur_next = best_slot_reg;
            tick_next = tick_reg + TIME_BITS'(1);
        end
        if (cmd.calc_step && fin)
        begin
            valid_next[cur_reg] = 1'b0;
            busy_next           = 1'b0;
        end
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
    end

    always_comb
    begin
        out_next               = '0;
        out_next.accepted      = wk_acc_reg;
        out_next.running_valid = wk_run_reg;
        out_next.finished      = wk_fin_reg;
        out_next.time_now      = TIME_FIELD_W'(tick_reg);
        if (wk_acc_reg)
            out_next.assigned_slot = SLOT_FIELD_W'(wk_slot_reg);
        if (wk_run_reg)
            out_next.running_slot = SLOT_FIELD_W'(cur_reg);
        if (wk_fin_reg)
        begin
            out_next.finished_slot = SLOT_FIELD_W'(cur_reg);
            out_next.turnaround    = TIME_FIELD_W'(ta_reg);
            out_next.waiting       = TIME_FIELD_W'(wait_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            busy_reg      <= 1'b0;
            cur_reg       <= '0;
            tick_reg      <= '0;
            scan_reg      <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            busy_reg      <= busy_next;
            cur_reg       <= cur_next;
            tick_reg      <= tick_next;
            scan_reg      <= scan_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Table write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_add)
        begin
            mem_pri[wr_addr]   <= pri_reg;
            mem_arr[wr_addr]   <= tick_reg;
            mem_burst[wr_addr] <= burst_reg;
        end
        if (wr_rem)
            mem_rem[wr_addr] <= wr_rem_data;
        if (rd_en)
        begin
            rd_slot_reg  <= rd_addr;
            rd_pri_reg   <= mem_pri[rd_addr];
            rd_arr_reg   <= mem_arr[rd_addr];
            rd_burst_reg <= mem_burst[rd_addr];
            rd_rem_reg   <= mem_rem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            pri_reg    <= task_data.task_priority;
            burst_reg  <= BURST_BITS'(task_data.task_burst);
            wk_acc_reg <= 1'b0;
            wk_run_reg <= 1'b0;
            wk_fin_reg <= 1'b0;
        end
        if (wr_add)
        begin
            wk_acc_reg  <= 1'b1;
            wk_slot_reg <= scan_idx;
        end
        if (take)
        begin
            best_slot_reg <= rd_slot_reg;
            best_pri_reg  <= rd_pri_reg;
            best_age_reg  <= age;
        end
        if (cmd.calc_step)
        begin
            wk_run_reg <= 1'b1;
            wk_fin_reg <= fin;
            ta_reg     <= tick_reg - rd_arr_reg;
        end
        if (cmd.wait_step)
            wait_reg <= ta_reg - TIME_BITS'(rd_burst_reg);
        if (cmd.load_out)
            out_reg <= out_next;
    end

endmodule

// ===== design/npps_ctrl.sv =====
module npps_ctrl
    import npps_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         task_valid,
    output logic         task_ready,
    input  npps_status_t status,
    output npps_cmd_t    cmd
);

    npps_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (task_valid)
                begin
                    if (status.in_op == OP_ADD)
                        state_next = ST_ADD;
                    else if (status.busy)
                        state_next = ST_RUN;
                    else
                        state_next = ST_PICK;
                end
            end
            ST_ADD:
            begin
                if (status.add_done)
                    state_next = ST_DONE;
            end
            ST_PICK:
            begin
                if (status.pick_done)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                state_next = status.run_go ? ST_CALC : ST_DONE;
            end
            ST_CALC:
            begin
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.res_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        task_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                task_ready = 1'b1;
                cmd.start  = task_valid;
            end
            ST_ADD:  cmd.add_step  = 1'b1;
            ST_PICK: cmd.pick_step = 1'b1;
            ST_RUN:  cmd.run_step  = 1'b1;
            ST_CALC: cmd.calc_step = 1'b1;
            ST_WAIT: cmd.wait_step = 1'b1;
            ST_DONE: cmd.load_out  = status.res_free;
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== design/nonpreemptive_priority_scheduler_top.sv =====
// Non-preemptive priority scheduler. Each beat on the task channel is either an add
// (operation 0: store a task arriving at the current tick in the lowest free slot;
// rejected if the burst is zero or the table is full) or a tick (operation 1: if no
// task runs, start the valid task with the lowest priority number, oldest arrival,
// then lowest slot; run the current task one tick and advance the wrapping time
// counter). Every task beat yields exactly one result beat; a completed task reports
// turnaround and waiting time and frees its slot. One item is processed at a time,
// paced by a controller and a datapath around a single-port task table with
// registered read. An add searches the valid bits linearly. A tick that must choose
// a new task first scans the table read port one entry per cycle; a tick while a
// task is running skips the scan. The result register lets the next task beat be
// accepted while the previous result still waits. No clearing pass is needed
// after reset.
module nonpreemptive_priority_scheduler_top
    import npps_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int TIME_BITS  = TIME_BITS_DEF,
    parameter int BURST_BITS = BURST_BITS_DEF
)(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      task_valid,
    output logic      task_ready,
    input  npps_in_t  task_data,
    output logic      result_valid,
    input  logic      result_ready,
    output npps_out_t result_data
);

    npps_cmd_t    cmd;
    npps_status_t status;

    // Sequence the item: accept, search or scan, run, load the result
    npps_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .task_valid (task_valid),
        .task_ready (task_ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Hold the task table, time counter, running task and result register
    npps_dp #(
        .SLOTS      (SLOTS),
        .TIME_BITS  (TIME_BITS),
        .BURST_BITS (BURST_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .task_data    (task_data),
        .result_data  (result_data),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

    // Drop ready after taking a beat: one item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (task_valid && task_ready) |=> !task_ready)
        else $error("task accepted while an item is still in work");

    // Load the result register only when it is empty or draining
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!result_valid || result_ready))
        else $error("result overwritten before it was taken");

    // A completion always belongs to the task that ran in the same tick
    a_fin_is_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.finished) |->
            (result_data.running_valid &&
             (result_data.finished_slot == result_data.running_slot)))
        else $error("finished task differs from running task");

endmodule

// ===== sim/npps_checker.sv =====
`timescale 1ns / 100ps

module npps_checker
    import npps_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      task_valid,
    input  logic      task_ready,
    input  npps_in_t  task_data,
    input  logic      result_valid,
    input  logic      result_ready,
    input  npps_out_t result_data,
    output int        mismatches,
    output int        pending
);

    localparam int SLOTS       = SLOTS_DEF;
    localparam int MAX_REPORTS = 10;

    // Shadow copy of the task table and the CPU
    logic                     slot_used    [SLOTS];
    logic [PRI_W-1:0]         slot_pri     [SLOTS];
    logic [TIME_FIELD_W-1:0]  slot_arrival [SLOTS];
    logic [BURST_FIELD_W-1:0] slot_burst   [SLOTS];
    logic [BURST_FIELD_W-1:0] slot_left    [SLOTS];
    logic                     cpu_busy;
    logic [SLOT_FIELD_W-1:0]  cpu_slot;
    logic [TIME_FIELD_W-1:0]  clock_ticks;

    npps_out_t outcome_q[$];
    int        results_checked;

    // Apply one task beat to the shadow table and return the result it yields.
    function automatic npps_out_t schedule_step(input npps_in_t beat);
        npps_out_t               r;
        logic                    found;
        int                      s;
        int                      best;
        logic [PRI_W-1:0]        best_pri;
        logic [TIME_FIELD_W-1:0] best_age;
        logic [TIME_FIELD_W-1:0] age;
        logic [TIME_FIELD_W-1:0] ta;
        r     = '0;
        found = 1'b0;
        best  = 0;
        best_pri = '0;
        best_age = '0;
        if (beat.operation == OP_ADD) begin
            if (beat.task_burst != '0) begin
                for (s = 0; s < SLOTS && !found; s++) begin
                    if (!slot_used[s]) begin
                        found           = 1'b1;
                        slot_used[s]    = 1'b1;
                        slot_pri[s]     = beat.task_priority;
                        slot_arrival[s] = clock_ticks;
                        slot_burst[s]   = beat.task_burst;
                        slot_left[s]    = beat.task_burst;
                        r.accepted      = 1'b1;
                        r.assigned_slot = s[SLOT_FIELD_W-1:0];
                    end
                end
            end
        end else begin
            if (!cpu_busy) begin
                // lowest number, then oldest arrival (age wraps), then lowest slot
                for (s = 0; s < SLOTS; s++) begin
                    if (slot_used[s]) begin
                        age = clock_ticks - slot_arrival[s];
                        if (!found || slot_pri[s] < best_pri ||
                            (slot_pri[s] == best_pri && age > best_age)) begin
                            found    = 1'b1;
                            best     = s;
                            best_pri = slot_pri[s];
                            best_age = age;
                        end
                    end
                end
                if (found) begin
                    cpu_busy = 1'b1;
                    cpu_slot = best[SLOT_FIELD_W-1:0];
                end
            end
            clock_ticks = clock_ticks + 1'b1;
            if (cpu_busy) begin
                r.running_valid = 1'b1;
                r.running_slot  = cpu_slot;
                if (slot_left[cpu_slot] != '0)
                    slot_left[cpu_slot] = slot_left[cpu_slot] - 1'b1;
                if (slot_left[cpu_slot] == '0) begin
                    ta              = clock_ticks - slot_arrival[cpu_slot];
                    r.finished      = 1'b1;
                    r.finished_slot = cpu_slot;
                    r.turnaround    = ta;
                    r.waiting       = ta - slot_burst[cpu_slot];
                    slot_used[cpu_slot] = 1'b0;
                    cpu_busy        = 1'b0;
                end
            end
        end
        r.time_now = clock_ticks;
        return r;
    endfunction

    function automatic string describe(input npps_out_t o);
        return {$sformatf("acc=%0d aslot=%0d run=%0d rslot=%0d fin=%0d fslot=%0d",
                          o.accepted, o.assigned_slot, o.running_valid, o.running_slot,
                          o.finished, o.finished_slot),
                $sformatf(" ta=%0d wait=%0d now=%0d",
                          o.turnaround, o.waiting, o.time_now)};
    endfunction

    task automatic check_result(input npps_out_t got);
        npps_out_t want;
        string     diff;
        results_checked++;
        if (outcome_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("[%0t] result beat %0d with nothing outstanding: %s",
                         $time, results_checked, describe(got));
        end else begin
            want = outcome_q.pop_front();
            diff = "";
            if (got.accepted      !== want.accepted)      diff = {diff, " accepted"};
            if (got.assigned_slot !== want.assigned_slot) diff = {diff, " assigned_slot"};
            if (got.running_valid !== want.running_valid) diff = {diff, " running_valid"};
            if (got.running_slot  !== want.running_slot)  diff = {diff, " running_slot"};
            if (got.finished      !== want.finished)      diff = {diff, " finished"};
            if (got.finished_slot !== want.finished_slot) diff = {diff, " finished_slot"};
            if (got.turnaround    !== want.turnaround)    diff = {diff, " turnaround"};
            if (got.waiting       !== want.waiting)       diff = {diff, " waiting"};
            if (got.time_now      !== want.time_now)      diff = {diff, " time_now"};
            if (diff != "") begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("[%0t] result beat %0d differs in:%s",
                             $time, results_checked, diff);
                    $display("    expected %s", describe(want));
                    $display("    actual   %s", describe(got));
                end
            end
        end
    endtask

    // Check the outgoing beat before queueing the new one: a beat that leaves
    // at the same edge always belongs to an older task beat.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int s = 0; s < SLOTS; s++) begin
                slot_used[s]    = 1'b0;
                slot_pri[s]     = '0;
                slot_arrival[s] = '0;
                slot_burst[s]   = '0;
                slot_left[s]    = '0;
            end
            cpu_busy        = 1'b0;
            cpu_slot        = '0;
            clock_ticks     = '0;
            outcome_q.delete();
            results_checked = 0;
            mismatches      = 0;
            pending         = 0;
        end else begin
            if (result_valid && result_ready)
                check_result(result_data);
            if (task_valid && task_ready)
                outcome_q.insert(outcome_q.size(), schedule_step(task_data));
            pending = outcome_q.size();
        end
    end

endmodule

// ===== sim/tb_nonpreemptive_priority_scheduler_top.sv =====
`timescale 1ns / 100ps

module tb_nonpreemptive_priority_scheduler_top;
    import npps_pkg::*;

    // Largest burst the field holds
    localparam int LONGEST    = (1 << BURST_FIELD_W) - 1;

    typedef enum logic [1:0] {
        RX_OPEN,    // take every beat
        RX_COIN,    // take about half
        RX_SPARSE,  // take about one in four
        RX_HOLD     // hold off at the start of the window, then open
    } rx_mode_t;

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      task_valid   = 1'b0;
    logic      task_ready;
    npps_in_t  task_data    = '0;
    logic      result_valid;
    logic      result_ready = 1'b0;
    npps_out_t result_data;

    int mismatches;
    int pending;

    // Stimulus bookkeeping
    int   items_sent   = 0;
    int   ticks_sent   = 0;
    int   results_seen = 0;
    int   live_tasks   = 0;
    int   done_tasks   = 0;
    int   burst_left   = 0;
    logic full_speed   = 1'b0;

    rx_mode_t   rx_mode;
    logic [4:0] rx_window;
    int         rx_hold;

    // Clock: 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    nonpreemptive_priority_scheduler_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .task_valid   (task_valid),
        .task_ready   (task_ready),
        .task_data    (task_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    npps_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .task_valid   (task_valid),
        .task_ready   (task_ready),
        .task_data    (task_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    // Receiver: pick a new stall mode each time the 5-bit window counter wraps; run
    // wide open while a full-speed stretch is in progress.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ready <= 1'b0;
            rx_mode      <= RX_OPEN;
            rx_window    <= '0;
            rx_hold      <= 0;
        end
        else
        begin
            rx_window <= rx_window + 1'b1;
            if (rx_window == '0)
            begin
                rx_mode <= rx_mode_t'($urandom_range(0, 3));
                rx_hold <= $urandom_range(1, 12);
            end
            if (full_speed)
                result_ready <= 1'b1;
            else
                case (rx_mode)
                    RX_OPEN:   result_ready <= 1'b1;
                    RX_COIN:   result_ready <= $urandom_range(0, 1);
                    RX_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
                    default:   result_ready <= (rx_window >= rx_hold);
                endcase
        end
    end

    // Track result beats so the stimulus can tell when the table is empty.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            results_seen <= 0;
            live_tasks   <= 0;
            done_tasks   <= 0;
        end
        else if (result_valid && result_ready)
        begin
            results_seen <= results_seen + 1;
            live_tasks   <= live_tasks + int'(result_data.accepted)
                                       - int'(result_data.finished);
            done_tasks   <= done_tasks + int'(result_data.finished);
        end
    end

    // Send one task beat. Outside full-speed stretches, beats go out in bursts
    // of random length with random idle gaps between the bursts. Returns at
    // the edge where the beat is accepted, with valid still high.
    task automatic send_item(input logic op, input logic [PRI_W-1:0] pri,
                             input logic [BURST_FIELD_W-1:0] burst);
        npps_in_t beat;
        int       gap;
        if (!full_speed)
        begin
            if (burst_left == 0)
            begin
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                burst_left = $urandom_range(1, 12);
                if (gap > 0)
                begin
                    task_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            burst_left--;
        end
        beat.operation     = op;
        beat.task_priority = pri;
        beat.task_burst    = burst;
        task_data  <= beat;
        task_valid <= 1'b1;
        @(posedge clk);
        while (!task_ready) @(posedge clk);
        items_sent++;
        if (op == OP_TICK)
            ticks_sent++;
    endtask

    // Tick one beat at a time until every stored task has completed.
    task automatic drain_table();
        do
        begin
            task_valid <= 1'b0;
            @(posedge clk);
            while (results_seen != items_sent) @(posedge clk);
            if (live_tasks != 0)
                send_item(OP_TICK, '0, '0);
        end
        while (live_tasks != 0);
    endtask

    function automatic logic [PRI_W-1:0] pick_priority();
        // mostly the nominal 1..10 range, now and then anything the field holds
        if ($urandom_range(0, 9) == 0)
            return PRI_W'($urandom_range(0, 15));
        return PRI_W'($urandom_range(1, 10));
    endfunction

    function automatic logic [BURST_FIELD_W-1:0] pick_burst();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return '0;
        if (roll < 88)
            return BURST_FIELD_W'($urandom_range(1, 15));
        return BURST_FIELD_W'($urandom_range(16, 255));
    endfunction

    initial
    begin : stimulus
        int i;
        int round;
        int add_pct;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: idle tick on an empty table, zero burst, fill every slot
        // (several priorities tie at one arrival, so the slot decides), then an
        // add against the full table, a few ticks, and a refill of a freed slot.
        send_item(OP_TICK, '0, '0);
        send_item(OP_ADD, 4'd1, '0);
        for (i = 0; i < SLOTS_DEF; i++)
            send_item(OP_ADD,
                      (i < 12) ? PRI_W'((i * 7) % 16) : 4'd5,
                      (i == 9) ? 12'd30 : BURST_FIELD_W'(i % 3 + 1));
        send_item(OP_ADD, 4'd2, BURST_FIELD_W'(LONGEST));
        send_item(OP_TICK, '0, '0);
        send_item(OP_ADD, 4'd11, 12'd2);
        send_item(OP_TICK, 4'd15, 12'hFFF);
        send_item(OP_TICK, '0, '0);
        drain_table();

        // Full-speed stretch: arrivals at different ticks wait behind a long
        // priority-0 blocker, so the pick after it compares ages and priorities.
        full_speed <= 1'b1;
        send_item(OP_ADD, 4'd5, 12'd3);
        send_item(OP_ADD, 4'd0, 12'd20);
        repeat (3) send_item(OP_TICK, '0, '0);
        send_item(OP_ADD, 4'd5, 12'd2);
        repeat (5) send_item(OP_TICK, '0, '0);
        send_item(OP_ADD, 4'd5, 12'd4);
        send_item(OP_ADD, 4'd4, 12'd1);
        send_item(OP_ADD, 4'd5, 12'd1);
        full_speed <= 1'b0;
        drain_table();

        // Random: rounds with different add rates, so the table swings between
        // nearly empty and full.
        for (round = 0; round < 7; round++)
        begin
            add_pct = 15 + 20 * $urandom_range(0, 3);
            for (i = 0; i < 100; i++)
            begin
                if ($urandom_range(0, 99) < add_pct)
                    send_item(OP_ADD, pick_priority(), pick_burst());
                else
                    send_item(OP_TICK, PRI_W'($urandom_range(0, 15)),
                              BURST_FIELD_W'($urandom_range(0, 4095)));
            end
        end

        // Drop valid, wait for the last result, then let the block settle.
        task_valid <= 1'b0;
        while (results_seen != items_sent) @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Sent %0d task beats (%0d ticks, %0d adds); %0d tasks ran to completion.",
                 items_sent, ticks_sent, items_sent - ticks_sent, done_tasks);
        $display("Covered a full table, rejected adds, priority ties and stalls on both sides.");
        if (mismatches == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial
    begin
        #(4_000_000);
        $display("Timed out waiting on the scheduler");
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
design/npps_pkg.sv
design/npps_dp.sv
design/npps_ctrl.sv
design/nonpreemptive_priority_scheduler_top.sv
sim/npps_checker.sv
sim/tb_nonpreemptive_priority_scheduler_top.sv
